### hdl/gcdist_pkg.sv
// Shared types, widths, constants and helper functions of the great-circle distance unit.
// Every other file refers to this package by scoped names; it depends on nothing.
package gcdist_pkg;

    // Fraction bits of the internal fixed-point values: signed Q3.F (W) and unsigned Q1.F (UW).
    localparam int F = 30;
    localparam int W = F + 4;
    localparam int UW = F + 1;

    localparam int LAT_W = 28;
    localparam int LON_W = 29;
    localparam int DIST_W = 25;
    localparam int MAG_W = 28;
    localparam int HR_W = 36;
    localparam int TR_W = 24;
    localparam int ZW = W - 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam int SQ_STEPS = F + 1;
    localparam int SQ_REM_W = F + 3;
    localparam int SQ_ROOT_W = F + 2;
    localparam int SQ_RAD_W = 2 * F + 2;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
    localparam logic [HR_W-1:0] HALF_RAD_Q62 = HR_W'(PI_Q62 / 64'd360000000);
    localparam int RAD_SH = 62 - F;
    localparam logic [MAG_W+HR_W:0] RAD_ROUND = (MAG_W + HR_W + 1)'(64'd1 << (61 - F));

    localparam logic signed [LAT_W-1:0] LAT_MAX = LAT_W'(90000000);
    localparam logic signed [LON_W-1:0] LON_MAX = LON_W'(180000000);
    localparam logic [MAG_W:0] HALF_TURN = (MAG_W + 1)'(180000000);
    localparam logic [MAG_W:0] FULL_TURN = (MAG_W + 1)'(360000000);

    localparam logic [UW-1:0] ONE_Q = {1'b1, {F{1'b0}}};
    localparam logic [TR_W-1:0] TWO_RADIUS_M = TR_W'(12742000);
    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(20015087);

    typedef struct packed {
        logic [MAG_W-1:0] dlat;
        logic [MAG_W-1:0] dlon;
        logic [MAG_W-1:0] lat1x2;
        logic [MAG_W-1:0] lat2x2;
    } pair_item_t;

    typedef logic [F-1:0][W-1:0] atan_tab_t;

    function automatic logic [63:0] rshift_round(input logic [63:0] v, input int s);
        logic [63:0] r;
        if (s == 0)
        begin
            r = v;
        end
        else
        begin
            r = (v + (64'd1 << (s - 1))) >> s;
        end
        return r;
    endfunction

    localparam logic signed [W-1:0] CORDIC_X0 = W'(rshift_round(64'd667681663043, 40 - F));

    // Restoring long division, used only while the constant table is built.
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) from its power series (pi/4 for i = 0), in Q62, then rounded to Q.F.
    function automatic atan_tab_t build_atan();
        atan_tab_t tab;
        logic [64:0] t;
        logic [63:0] term;
        logic [63:0] den;
        int sh;
        for (int i = 0; i < F; i++)
        begin
            t = '0;
            if (i == 0)
            begin
                t = {1'b0, PI_Q62 >> 2};
            end
            else
            begin
                for (int k = 0; i * (2 * k + 1) <= 62; k++)
                begin
                    sh = 62 - i * (2 * k + 1);
                    den = 64'(2 * k + 1);
                    term = div_u64(64'd1 << sh, den);
                    if (k[0])
                    begin
                        t = t - {1'b0, term};
                    end
                    else
                    begin
                        t = t + {1'b0, term};
                    end
                end
            end
            t = (t + (65'd1 << (61 - F))) >> (62 - F);
            tab[i] = W'(t);
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan();

    function automatic logic [UW-1:0] clamp_unit(input logic signed [W-1:0] v);
        logic [UW-1:0] r;
        if (v[W-1])
        begin
            r = '0;
        end
        else if (v > $signed({{(W - UW){1'b0}}, ONE_Q}))
        begin
            r = ONE_Q;
        end
        else
        begin
            r = v[UW-1:0];
        end
        return r;
    endfunction

    function automatic logic [UW-1:0] mul_round(input logic [UW-1:0] a, input logic [UW-1:0] b);
        logic [2*UW-1:0] p;
        p = {{UW{1'b0}}, a} * {{UW{1'b0}}, b};
        p = p + (2 * UW)'(64'd1 << (F - 1));
        return UW'(p >> F);
    endfunction

    function automatic logic signed [W-1:0] to_rad(input logic [MAG_W-1:0] m);
        logic [MAG_W+HR_W-1:0] p;
        logic [MAG_W+HR_W:0] s;
        p = {{HR_W{1'b0}}, m} * {{MAG_W{1'b0}}, HALF_RAD_Q62};
        s = {1'b0, p} + RAD_ROUND;
        return W'(s >> RAD_SH);
    endfunction

endpackage

### hdl/great_circle_distance_unit.sv
// Top level of the great-circle distance unit: front end, decoupling queue and back end.
// Depends on gcdist_pkg, gcdist_front, gcdist_queue and gcdist_back.
//
//   channel  | handshake     | beat contents
//   ---------+---------------+---------------------------------------------------------
//   input    | push / full   | first_latitude, first_longitude, second_latitude,
//            |               | second_longitude (signed micro-degrees)
//   result   | empty / pop   | distance_meters (unsigned meters)
//
// One pair per cycle unless a held result stalls; every stage holds one item in flight.
// From the accepting edge, which loads the front stage, an item passes through one queue
// slot, radian conversion, F CORDIC rotation stages, three product stages, F + 1 root
// stages, F atan2 stages and the result register before the result reaches the ports.
// Async reset clears only the valid flags, queue pointers and count, and the result flag.
// A held result (empty low, pop low) freezes the back end; the four-entry queue and the
// front register then fill before full rises.
module great_circle_distance_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [gcdist_pkg::LAT_W-1:0] first_latitude,
    input  logic signed [gcdist_pkg::LON_W-1:0] first_longitude,
    input  logic signed [gcdist_pkg::LAT_W-1:0] second_latitude,
    input  logic signed [gcdist_pkg::LON_W-1:0] second_longitude,
    output logic                              empty,
    input  logic                              pop,
    output logic [gcdist_pkg::DIST_W-1:0]     distance_meters
);

    logic f_valid;
    logic f_ready;
    gcdist_pkg::pair_item_t f_item;
    logic q_valid;
    logic q_take;
    gcdist_pkg::pair_item_t q_item;

    gcdist_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .first_latitude   (first_latitude),
        .first_longitude  (first_longitude),
        .second_latitude  (second_latitude),
        .second_longitude (second_longitude),
        .q_ready          (f_ready),
        .q_valid          (f_valid),
        .q_item           (f_item)
    );

    gcdist_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_take  (q_take),
        .out_item  (q_item)
    );

    gcdist_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_take          (q_take),
        .pop             (pop),
        .empty           (empty),
        .distance_meters (distance_meters)
    );

endmodule

### hdl/gcdist_front.sv
// Front end: accepts one point pair per beat, clamps the coordinates and reduces them to
// the angle magnitudes the back end needs. Depends on gcdist_pkg.
module gcdist_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [gcdist_pkg::LAT_W-1:0] first_latitude,
    input  logic signed [gcdist_pkg::LON_W-1:0] first_longitude,
    input  logic signed [gcdist_pkg::LAT_W-1:0] second_latitude,
    input  logic signed [gcdist_pkg::LON_W-1:0] second_longitude,
    input  logic                             q_ready,
    output logic                             q_valid,
    output gcdist_pkg::pair_item_t           q_item
);

    logic front_valid_reg;
    logic front_valid_next;
    gcdist_pkg::pair_item_t front_item_reg;
    gcdist_pkg::pair_item_t item_next;

    logic signed [gcdist_pkg::LAT_W-1:0] lat1_c;
    logic signed [gcdist_pkg::LAT_W-1:0] lat2_c;
    logic signed [gcdist_pkg::LON_W-1:0] lon1_c;
    logic signed [gcdist_pkg::LON_W-1:0] lon2_c;
    logic signed [gcdist_pkg::LAT_W:0] dlat;
    logic signed [gcdist_pkg::LON_W:0] dlon;
    logic [gcdist_pkg::LAT_W:0] dlat_mag;
    logic [gcdist_pkg::LON_W:0] dlon_mag;
    logic [gcdist_pkg::MAG_W:0] dlon_wrap;
    logic [gcdist_pkg::LAT_W-1:0] lat1_mag;
    logic [gcdist_pkg::LAT_W-1:0] lat2_mag;
    logic accept;
    logic transfer;

    assign full = front_valid_reg && !q_ready;
    assign accept = push && !full;
    assign transfer = front_valid_reg && q_ready;
    assign q_valid = front_valid_reg;
    assign q_item = front_item_reg;

    always_comb
    begin
        lat1_c = first_latitude;
        if (first_latitude > gcdist_pkg::LAT_MAX)
            lat1_c = gcdist_pkg::LAT_MAX;
        else if (first_latitude < -gcdist_pkg::LAT_MAX)
            lat1_c = -gcdist_pkg::LAT_MAX;
        lat2_c = second_latitude;
        if (second_latitude > gcdist_pkg::LAT_MAX)
            lat2_c = gcdist_pkg::LAT_MAX;
        else if (second_latitude < -gcdist_pkg::LAT_MAX)
            lat2_c = -gcdist_pkg::LAT_MAX;
        lon1_c = first_longitude;
        if (first_longitude > gcdist_pkg::LON_MAX)
            lon1_c = gcdist_pkg::LON_MAX;
        else if (first_longitude < -gcdist_pkg::LON_MAX)
            lon1_c = -gcdist_pkg::LON_MAX;
        lon2_c = second_longitude;
        if (second_longitude > gcdist_pkg::LON_MAX)
            lon2_c = gcdist_pkg::LON_MAX;
        else if (second_longitude < -gcdist_pkg::LON_MAX)
            lon2_c = -gcdist_pkg::LON_MAX;

        dlat = {lat2_c[gcdist_pkg::LAT_W-1], lat2_c} - {lat1_c[gcdist_pkg::LAT_W-1], lat1_c};
        dlon = {lon2_c[gcdist_pkg::LON_W-1], lon2_c} - {lon1_c[gcdist_pkg::LON_W-1], lon1_c};
        dlat_mag = dlat[gcdist_pkg::LAT_W] ? -dlat : dlat;
        dlon_mag = dlon[gcdist_pkg::LON_W] ? -dlon : dlon;

        // More than half a turn apart: go the short way round.
        dlon_wrap = dlon_mag[gcdist_pkg::MAG_W:0];
        if (dlon_wrap > gcdist_pkg::HALF_TURN)
            dlon_wrap = gcdist_pkg::FULL_TURN - dlon_wrap;

        lat1_mag = lat1_c[gcdist_pkg::LAT_W-1] ? -lat1_c : lat1_c;
        lat2_mag = lat2_c[gcdist_pkg::LAT_W-1] ? -lat2_c : lat2_c;

        item_next.dlat = gcdist_pkg::MAG_W'(dlat_mag);
        item_next.dlon = gcdist_pkg::MAG_W'(dlon_wrap);
        item_next.lat1x2 = {lat1_mag[gcdist_pkg::MAG_W-2:0], 1'b0};
        item_next.lat2x2 = {lat2_mag[gcdist_pkg::MAG_W-2:0], 1'b0};
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
            front_valid_next = 1'b1;
        else if (transfer)
            front_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            front_item_reg <= item_next;
    end

endmodule

### hdl/gcdist_queue.sv
// Short queue that decouples the front end from the arithmetic back end.
// Depends on gcdist_pkg for the item type and depth.
module gcdist_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  gcdist_pkg::pair_item_t in_item,
    output logic                   out_valid,
    input  logic                   out_take,
    output gcdist_pkg::pair_item_t out_item
);

    gcdist_pkg::pair_item_t slot_reg [gcdist_pkg::QUEUE_DEPTH];
    logic [gcdist_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [gcdist_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [gcdist_pkg::QPTR_W:0] count_reg;
    logic [gcdist_pkg::QPTR_W:0] count_next;
    logic wr;
    logic rd;

    assign in_ready = count_reg != (gcdist_pkg::QPTR_W + 1)'(gcdist_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign wr = in_valid && in_ready;
    assign rd = out_take && out_valid;
    assign out_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wr_ptr_reg] <= in_item;
    end

endmodule

### hdl/gcdist_sincos.sv
// Pipelined rotation-mode CORDIC, one iteration per stage, giving a clamped sine and cosine.
// Depends on gcdist_pkg for widths, the start gain and the angle table.
module gcdist_sincos (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [gcdist_pkg::W-1:0] theta,
    output logic                           out_valid,
    output logic [gcdist_pkg::UW-1:0]      sin_val,
    output logic [gcdist_pkg::UW-1:0]      cos_val
);

    localparam int N = gcdist_pkg::F;

    logic [N-1:0] v_reg;
    logic signed [gcdist_pkg::W-1:0] x_reg [N];
    logic signed [gcdist_pkg::W-1:0] y_reg [N];
    logic signed [gcdist_pkg::W-1:0] z_reg [N];
    logic signed [gcdist_pkg::W-1:0] x_in [N];
    logic signed [gcdist_pkg::W-1:0] y_in [N];
    logic signed [gcdist_pkg::W-1:0] z_in [N];
    logic signed [gcdist_pkg::W-1:0] x_next [N];
    logic signed [gcdist_pkg::W-1:0] y_next [N];
    logic signed [gcdist_pkg::W-1:0] z_next [N];

    always_comb
    begin
        x_in[0] = gcdist_pkg::CORDIC_X0;
        y_in[0] = '0;
        z_in[0] = theta;
        for (int i = 1; i < N; i++)
        begin
            x_in[i] = x_reg[i-1];
            y_in[i] = y_reg[i-1];
            z_in[i] = z_reg[i-1];
        end
        for (int i = 0; i < N; i++)
        begin
            if (!z_in[i][gcdist_pkg::W-1])
            begin
                x_next[i] = x_in[i] - (y_in[i] >>> i);
                y_next[i] = y_in[i] + (x_in[i] >>> i);
                z_next[i] = z_in[i] - $signed(gcdist_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x_next[i] = x_in[i] + (y_in[i] >>> i);
                y_next[i] = y_in[i] - (x_in[i] >>> i);
                z_next[i] = z_in[i] + $signed(gcdist_pkg::ATAN_TAB[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign sin_val = gcdist_pkg::clamp_unit(y_reg[N-1]);
    assign cos_val = gcdist_pkg::clamp_unit(x_reg[N-1]);

endmodule

### hdl/gcdist_sqrt.sv
// Pipelined digit-by-digit square root of a Q.F value, one root bit per stage,
// rounded to nearest at the end. Depends on gcdist_pkg.
module gcdist_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [gcdist_pkg::UW-1:0] value,
    output logic                      out_valid,
    output logic [gcdist_pkg::UW-1:0] root
);

    localparam int N = gcdist_pkg::SQ_STEPS;
    localparam int RW = gcdist_pkg::SQ_REM_W;
    localparam int TW = gcdist_pkg::SQ_ROOT_W;
    localparam int F = gcdist_pkg::F;

    logic [N-1:0] v_reg;
    logic [gcdist_pkg::UW-1:0] val_reg [N];
    logic [RW-1:0] rem_reg [N];
    logic [TW-1:0] root_reg [N];
    logic [gcdist_pkg::UW-1:0] val_in [N];
    logic [RW-1:0] rem_in [N];
    logic [TW-1:0] root_in [N];
    logic [RW-1:0] rem_next [N];
    logic [TW-1:0] root_next [N];
    logic [gcdist_pkg::SQ_RAD_W-1:0] rad [N];
    logic [RW+1:0] rem_w [N];
    logic [RW+1:0] trial [N];
    logic [TW-1:0] rounded;

    always_comb
    begin
        val_in[0] = value;
        rem_in[0] = '0;
        root_in[0] = '0;
        for (int j = 1; j < N; j++)
        begin
            val_in[j] = val_reg[j-1];
            rem_in[j] = rem_reg[j-1];
            root_in[j] = root_reg[j-1];
        end
        // Stage j brings down the bit pair at 2(F-j) of value * 2^F.
        for (int j = 0; j < N; j++)
        begin
            rad[j] = {1'b0, val_in[j], {F{1'b0}}};
            rem_w[j] = {rem_in[j], rad[j][2*(F-j)+1 -: 2]};
            trial[j] = {1'b0, root_in[j], 2'b01};
            if (rem_w[j] >= trial[j])
            begin
                rem_next[j] = RW'(rem_w[j] - trial[j]);
                root_next[j] = {root_in[j][TW-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = RW'(rem_w[j]);
                root_next[j] = {root_in[j][TW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < N; j++)
            begin
                val_reg[j] <= val_in[j];
                rem_reg[j] <= rem_next[j];
                root_reg[j] <= root_next[j];
            end
        end
    end

    assign rounded = root_reg[N-1] + TW'(rem_reg[N-1] > {1'b0, root_reg[N-1]});
    assign root = rounded[gcdist_pkg::UW-1:0];
    assign out_valid = v_reg[N-1];

endmodule

### hdl/gcdist_atan2.sv
// Pipelined vectoring-mode CORDIC, one iteration per stage, giving atan2(y, x) in Q.F.
// Depends on gcdist_pkg for widths and the angle table.
module gcdist_atan2 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [gcdist_pkg::UW-1:0]       y_val,
    input  logic [gcdist_pkg::UW-1:0]       x_val,
    output logic                            out_valid,
    output logic signed [gcdist_pkg::W-1:0] angle
);

    localparam int N = gcdist_pkg::F;
    localparam int W = gcdist_pkg::W;

    logic [N-1:0] v_reg;
    logic signed [W-1:0] x_reg [N];
    logic signed [W-1:0] y_reg [N];
    logic signed [W-1:0] z_reg [N];
    logic signed [W-1:0] x_in [N];
    logic signed [W-1:0] y_in [N];
    logic signed [W-1:0] z_in [N];
    logic signed [W-1:0] x_next [N];
    logic signed [W-1:0] y_next [N];
    logic signed [W-1:0] z_next [N];

    always_comb
    begin
        x_in[0] = {{(W - gcdist_pkg::UW){1'b0}}, x_val};
        y_in[0] = {{(W - gcdist_pkg::UW){1'b0}}, y_val};
        z_in[0] = '0;
        for (int i = 1; i < N; i++)
        begin
            x_in[i] = x_reg[i-1];
            y_in[i] = y_reg[i-1];
            z_in[i] = z_reg[i-1];
        end
        // Rotate toward the x axis; y of exactly zero counts with the negative side.
        for (int i = 0; i < N; i++)
        begin
            if (!y_in[i][W-1] && (y_in[i] != '0))
            begin
                x_next[i] = x_in[i] + (y_in[i] >>> i);
                y_next[i] = y_in[i] - (x_in[i] >>> i);
                z_next[i] = z_in[i] + $signed(gcdist_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x_next[i] = x_in[i] - (y_in[i] >>> i);
                y_next[i] = y_in[i] + (x_in[i] >>> i);
                z_next[i] = z_in[i] - $signed(gcdist_pkg::ATAN_TAB[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign angle = z_reg[N-1];

endmodule

### hdl/gcdist_back.sv
// Back end: radian conversion, four sine/cosine units, the haversine products, two square
// roots, atan2, the radius scaling and the result register. Depends on gcdist_pkg and the
// gcdist_sincos, gcdist_sqrt and gcdist_atan2 units.
module gcdist_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  gcdist_pkg::pair_item_t       q_item,
    output logic                         q_take,
    input  logic                         pop,
    output logic                         empty,
    output logic [gcdist_pkg::DIST_W-1:0] distance_meters
);

    localparam int F = gcdist_pkg::F;
    localparam int UW = gcdist_pkg::UW;
    localparam int W = gcdist_pkg::W;
    localparam int ZW = gcdist_pkg::ZW;
    localparam int PW = gcdist_pkg::ZW + gcdist_pkg::TR_W;

    logic en;
    logic rad_valid_reg;
    logic signed [W-1:0] th_dlat_reg;
    logic signed [W-1:0] th_dlon_reg;
    logic signed [W-1:0] th_lat1_reg;
    logic signed [W-1:0] th_lat2_reg;

    logic sc_valid;
    logic [UW-1:0] s1;
    logic [UW-1:0] s2;
    logic [UW-1:0] c1;
    logic [UW-1:0] c2;

    logic [2:0] pv_reg;
    logic [UW-1:0] p_cc_reg;
    logic [UW-1:0] p_ss2_reg;
    logic [UW-1:0] p_ss1_reg;
    logic [UW-1:0] p_prod_reg;
    logic [UW-1:0] p_ss1d_reg;
    logic [UW-1:0] a_reg;
    logic [UW-1:0] b_reg;
    logic [UW:0] a_sum;

    logic sq_valid;
    logic [UW-1:0] root_a;
    logic [UW-1:0] root_b;

    logic at_valid;
    logic signed [W-1:0] angle;
    logic [ZW-1:0] angle_pos;
    logic [PW-1:0] dprod;
    logic [PW-1:0] dshift;
    logic [gcdist_pkg::DIST_W-1:0] dist_sat;

    logic out_full_reg;
    logic out_full_next;
    logic [gcdist_pkg::DIST_W-1:0] out_dist_reg;

    // The whole pipeline advances unless a waiting result is being held.
    assign en = !out_full_reg || pop;
    assign q_take = en && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rad_valid_reg <= 1'b0;
        else if (en)
            rad_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_dlat_reg <= gcdist_pkg::to_rad(q_item.dlat);
            th_dlon_reg <= gcdist_pkg::to_rad(q_item.dlon);
            th_lat1_reg <= gcdist_pkg::to_rad(q_item.lat1x2);
            th_lat2_reg <= gcdist_pkg::to_rad(q_item.lat2x2);
        end
    end

    gcdist_sincos u_sc_dlat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rad_valid_reg),
        .theta     (th_dlat_reg),
        .out_valid (sc_valid),
        .sin_val   (s1),
        .cos_val   ()
    );

    gcdist_sincos u_sc_dlon (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rad_valid_reg),
        .theta     (th_dlon_reg),
        .out_valid (),
        .sin_val   (s2),
        .cos_val   ()
    );

    gcdist_sincos u_sc_lat1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rad_valid_reg),
        .theta     (th_lat1_reg),
        .out_valid (),
        .sin_val   (),
        .cos_val   (c1)
    );

    gcdist_sincos u_sc_lat2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rad_valid_reg),
        .theta     (th_lat2_reg),
        .out_valid (),
        .sin_val   (),
        .cos_val   (c2)
    );

    assign a_sum = {1'b0, p_prod_reg} + {1'b0, p_ss1d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (en)
            pv_reg <= {pv_reg[1:0], sc_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_cc_reg <= gcdist_pkg::mul_round(c1, c2);
            p_ss2_reg <= gcdist_pkg::mul_round(s2, s2);
            p_ss1_reg <= gcdist_pkg::mul_round(s1, s1);
            p_prod_reg <= gcdist_pkg::mul_round(p_cc_reg, p_ss2_reg);
            p_ss1d_reg <= p_ss1_reg;
            if (a_sum > {1'b0, gcdist_pkg::ONE_Q})
            begin
                a_reg <= gcdist_pkg::ONE_Q;
                b_reg <= '0;
            end
            else
            begin
                a_reg <= a_sum[UW-1:0];
                b_reg <= gcdist_pkg::ONE_Q - a_sum[UW-1:0];
            end
        end
    end

    gcdist_sqrt u_sqrt_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pv_reg[2]),
        .value     (a_reg),
        .out_valid (sq_valid),
        .root      (root_a)
    );

    gcdist_sqrt u_sqrt_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pv_reg[2]),
        .value     (b_reg),
        .out_valid (),
        .root      (root_b)
    );

    gcdist_atan2 u_atan2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .y_val     (root_a),
        .x_val     (root_b),
        .out_valid (at_valid),
        .angle     (angle)
    );

    always_comb
    begin
        angle_pos = angle[W-1] ? '0 : angle[ZW-1:0];
        dprod = {{gcdist_pkg::TR_W{1'b0}}, angle_pos}
              * {{ZW{1'b0}}, gcdist_pkg::TWO_RADIUS_M};
        dshift = (dprod + PW'(64'd1 << (F - 1))) >> F;
        if (dshift > PW'(gcdist_pkg::DIST_MAX))
            dist_sat = gcdist_pkg::DIST_MAX;
        else
            dist_sat = dshift[gcdist_pkg::DIST_W-1:0];
    end

    always_comb
    begin
        out_full_next = out_full_reg;
        if (en && at_valid)
            out_full_next = 1'b1;
        else if (pop)
            out_full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else
            out_full_reg <= out_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (en && at_valid)
            out_dist_reg <= dist_sat;
    end

    assign empty = !out_full_reg;
    assign distance_meters = out_dist_reg;

endmodule

### hdl/gcdist_checker.sv
// Port-level checker for the great-circle distance unit, bound to the top level.
// Depends on gcdist_pkg for widths and the distance limit.
module gcdist_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              push,
    input logic                              full,
    input logic                              empty,
    input logic                              pop,
    input logic [gcdist_pkg::DIST_W-1:0]     distance_meters
);

    // Coming out of reset nothing is waiting and there is room.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result waiting right after reset");

    a_reset_room: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !full)
        else $error("input refused right after reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(distance_meters)))
        else $error("held result changed or vanished");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (distance_meters <= gcdist_pkg::DIST_MAX))
        else $error("distance beyond half the circumference");

endmodule

bind great_circle_distance_unit gcdist_checker u_gcdist_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .distance_meters (distance_meters)
);
